### sv/mhpq_pkg.sv
// Shared constants, codes and control/status types of the min-heap priority queue.
package mhpq_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = ADDR_W + 2;

  // Entry layout: priority in the upper half, payload in the lower half.
  localparam int PRIO_W  = 32;
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = PRIO_W + DATA_W;

  // Stream widths.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Request kinds.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // latch the incoming request
    logic enq_start;  // grow the heap by one entry
    logic set_full;   // respond full
    logic set_empty;  // respond empty
    logic dn_first;   // read root and last entry, shrink the heap
    logic dn_load;    // capture root payload and the moving entry
    logic up_rd;      // read the parent of the hole
    logic up_move;    // move the parent down into the hole
    logic dn_rd;      // read both children of the hole
    logic dn_move;    // move the smaller child up into the hole
    logic place;      // write the moving entry into the hole
    logic out_load;   // load the response register
  } mhpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_enq;
    logic full;
    logic empty;
    logic pos_zero;
    logic leaf;
    logic up_swap;
    logic dn_swap;
    logic out_busy;
  } mhpq_sts_t;

endpackage

### sv/mhpq_ctrl.sv
// Controller state machine that sequences the sift-up and sift-down walks.
module mhpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mhpq_pkg::mhpq_sts_t sts,
  output mhpq_pkg::mhpq_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DISP    = 8'b0000_0010,
    S_UP_RD   = 8'b0000_0100,
    S_UP_CMP  = 8'b0000_1000,
    S_DN_LOAD = 8'b0001_0000,
    S_DN_RD   = 8'b0010_0000,
    S_DN_CMP  = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // A new request is taken only between operations.
  assign s_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_enq) begin
          if (sts.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_FINISH;
          end else begin
            cmd.enq_start = 1'b1;
            state_next    = S_UP_RD;
          end
        end else if (sts.empty) begin
          cmd.set_empty = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.dn_first = 1'b1;
          state_next   = S_DN_LOAD;
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.up_rd  = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.up_move = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_DN_LOAD: begin
        cmd.dn_load = 1'b1;
        state_next  = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts.leaf) begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.dn_rd  = 1'b1;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_swap) begin
          cmd.dn_move = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/mhpq_dp.sv
// Datapath: heap memory, hole position, moving entry, count and response register.
module mhpq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tuser,
  input  logic [mhpq_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  mhpq_pkg::mhpq_cmd_t                 cmd,
  output mhpq_pkg::mhpq_sts_t                 sts
);

  localparam int ADDR_W  = mhpq_pkg::ADDR_W;
  localparam int CNT_W   = mhpq_pkg::CNT_W;
  localparam int EXT_W   = mhpq_pkg::EXT_W;
  localparam int ENTRY_W = mhpq_pkg::ENTRY_W;
  localparam int DATA_W  = mhpq_pkg::DATA_W;
  localparam int PRIO_W  = mhpq_pkg::PRIO_W;

  logic [ENTRY_W-1:0] mem [mhpq_pkg::CAPACITY];
  logic [ENTRY_W-1:0] rda;
  logic [ENTRY_W-1:0] rdb;

  logic [ADDR_W-1:0]  pos;
  logic [ENTRY_W-1:0] cur;
  logic [CNT_W-1:0]   count;
  logic               is_enq;
  logic [1:0]         rsp_status;
  logic [DATA_W-1:0]  result;

  logic [ADDR_W-1:0]  parent;
  logic [EXT_W-1:0]   lo;
  logic [EXT_W-1:0]   hi;
  logic [EXT_W-1:0]   count_ext;
  logic               hi_ok;
  logic               pick_hi;
  logic [ENTRY_W-1:0] child;
  logic [ADDR_W-1:0]  ra;
  logic [ADDR_W-1:0]  rb;
  logic               we;
  logic [ENTRY_W-1:0] wdata;

  // Index arithmetic around the hole.
  assign parent    = ADDR_W'((pos - 1'b1) >> 1);
  assign lo        = {1'b0, pos, 1'b1};
  assign hi        = lo + 1'b1;
  assign count_ext = EXT_W'(count);
  assign hi_ok     = hi < count_ext;

  // Smaller child; the left one wins a tie.
  assign pick_hi = hi_ok && (rdb[ENTRY_W-1 -: PRIO_W] < rda[ENTRY_W-1 -: PRIO_W]);
  assign child   = pick_hi ? rdb : rda;

  // Read address selection.
  always_comb begin
    ra = parent;
    rb = ADDR_W'(hi);
    if (cmd.dn_first) begin
      ra = '0;
      rb = ADDR_W'(count - 1'b1);
    end else if (cmd.dn_rd) begin
      ra = ADDR_W'(lo);
    end else if (cmd.up_rd) begin
      ra = parent;
    end
  end

  // Write port: the hole takes the moving entry, the parent or the child.
  assign we    = cmd.place | cmd.up_move | cmd.dn_move;
  assign wdata = cmd.place ? cur : (cmd.up_move ? rda : child);

  // Heap memory with one write and two registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    rda <= mem[ra];
    rdb <= mem[rb];
  end

  // Status toward the controller.
  assign sts.is_enq   = is_enq;
  assign sts.full     = (count == CNT_W'(mhpq_pkg::CAPACITY));
  assign sts.empty    = (count == '0);
  assign sts.pos_zero = (pos == '0);
  assign sts.leaf     = (lo >= count_ext);
  assign sts.up_swap  = rda[ENTRY_W-1 -: PRIO_W] > cur[ENTRY_W-1 -: PRIO_W];
  assign sts.dn_swap  = child[ENTRY_W-1 -: PRIO_W] < cur[ENTRY_W-1 -: PRIO_W];
  assign sts.out_busy = m_tvalid && !m_tready;

  // Hole position, moving entry and request registers.
  // The beat carries the priority in its low half; an entry keeps it in the high half.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pos        <= ADDR_W'(count);
      cur        <= {s_tdata[PRIO_W-1:0], s_tdata[mhpq_pkg::IN_TDATA_W-1:PRIO_W]};
      is_enq     <= (s_tuser == mhpq_pkg::REQ_ENQ);
      rsp_status <= mhpq_pkg::ST_OK;
      result     <= '0;
    end
    if (cmd.set_full) begin
      rsp_status <= mhpq_pkg::ST_FULL;
    end
    if (cmd.set_empty) begin
      rsp_status <= mhpq_pkg::ST_EMPTY;
    end
    if (cmd.dn_load) begin
      pos    <= '0;
      cur    <= rdb;
      result <= rda[DATA_W-1:0];
    end
    if (cmd.up_move) begin
      pos <= parent;
    end
    if (cmd.dn_move) begin
      pos <= pick_hi ? ADDR_W'(hi) : ADDR_W'(lo);
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.enq_start) begin
      count <= count + 1'b1;
    end else if (cmd.dn_first) begin
      count <= count - 1'b1;
    end
  end

  // Response register; a beat stays until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'b0, (count == '0), result, rsp_status};
    end
  end

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(mhpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // A response is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("response overwritten");

  // Starting an enqueue grows the heap by exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    cmd.enq_start |=> count == CNT_W'($past(count) + 1'b1))
    else $error("enqueue did not grow the count");

endmodule

### sv/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: controller plus datapath.
//
// Each beat on the slave side is one request: enqueue a (priority, payload)
// entry or dequeue the entry with the smallest priority; each request gives
// exactly one response beat with a status, the dequeued payload and an empty
// flag. Requests are handled one at a time. A full enqueue or an empty
// dequeue goes straight to the response; an enqueue climbs the new entry
// one level at a time from the last slot toward the root, and a dequeue
// moves the last entry to the root and sinks it one level at a time. The
// walk is paced by the heap memory: each level of the walk needs one
// registered read and then one compare and write. A request may be taken
// while the previous response still waits on the master side; the block
// holds a finished response until that beat is taken, and stalls for as
// long as it waits.
module min_heap_priority_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mhpq_pkg::IN_TDATA_W-1:0]     s_tdata,  // priority_req, payload
  input  logic                                s_tuser,  // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]    m_tdata   // status, out_payload, now_empty
);

  mhpq_pkg::mhpq_cmd_t cmd;
  mhpq_pkg::mhpq_sts_t sts;

  // Sequencer.
  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Heap storage and arithmetic.
  mhpq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
